// ===== rtl/owfm_pkg.sv =====
// ---------------------------------------------------------------------------
// owfm_pkg: shared types and constants of the field-oriented omni mixer
// cordic arctangent table and register map; stages pass vectors, not structs
// ---------------------------------------------------------------------------
package owfm_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int CW = 34;                       // cordic datapath width
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam int Q15_MAX = 32767;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = 2;

  localparam logic [0:0] REG_RUN_ENABLE = 1'b0;

  typedef logic signed [CW-1:0] cw_t;

  function automatic cw_t atan_turn(input int i);
    cw_t a;
    unique case (i)
      0: a = 34'sd536870912;  1: a = 34'sd316933406;  2: a = 34'sd167458907;
      3: a = 34'sd85004756;   4: a = 34'sd42667331;   5: a = 34'sd21354465;
      6: a = 34'sd10679838;   7: a = 34'sd5340245;    8: a = 34'sd2670163;
      9: a = 34'sd1335087;    10: a = 34'sd667544;    11: a = 34'sd333772;
      12: a = 34'sd166886;    13: a = 34'sd83443;     14: a = 34'sd41722;
      15: a = 34'sd20861;     16: a = 34'sd10430;     17: a = 34'sd5215;
      18: a = 34'sd2608;      19: a = 34'sd1304;
      default: a = '0;
    endcase
    return a;
  endfunction

  // rounded and clamped q1.15 from q4.30
  function automatic logic signed [15:0] to_q15(input cw_t v);
    cw_t r;
    r = (v + cw_t'(16384)) >>> 15;
    if (r > cw_t'(Q15_MAX)) return 16'sd32767;
    if (r < -cw_t'(Q15_MAX)) return -16'sd32767;
    return r[15:0];
  endfunction

endpackage

// ===== rtl/owfm_front.sv =====
// ---------------------------------------------------------------------------
// owfm_front: command intake and pipelined sine/cosine of 45deg - heading
// one cordic iteration per stage, items enter every cycle
// ---------------------------------------------------------------------------
module owfm_front import owfm_pkg::*; #(
  parameter int VEL_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic signed [VEL_BITS-1:0]  vx,
  input  logic signed [VEL_BITS-1:0]  vy,
  input  logic signed [VEL_BITS-1:0]  vw,
  input  logic [ANGLE_BITS-1:0]       head,
  output logic                        done,
  output logic signed [VEL_BITS-1:0]  ox,
  output logic signed [VEL_BITS-1:0]  oy,
  output logic signed [VEL_BITS-1:0]  ow,
  output logic signed [15:0]          cos_q,
  output logic signed [15:0]          sin_q
);

  localparam int NS = CORDIC_STEPS + 1;
  localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(1) << (ANGLE_BITS - 3);

  logic [NS-1:0]               vld_r;
  logic signed [VEL_BITS-1:0]  x_r [NS], y_r [NS], w_r [NS];
  logic [1:0]                  quad_r [NS];
  cw_t                         cx_r [NS], cy_r [NS], cz_r [NS];
  logic [ANGLE_BITS-1:0]       theta;
  logic [31:0]                 turns;

  assign theta = EIGHTH - head;
  assign turns = {theta, {(32-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    x_r[0] <= vx;
    y_r[0] <= vy;
    w_r[0] <= vw;
    quad_r[0] <= turns[31:30];
    cx_r[0] <= CORDIC_GAIN;
    cy_r[0] <= '0;
    cz_r[0] <= cw_t'({2'b00, turns[29:0]});
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      x_r[i+1] <= x_r[i];
      y_r[i+1] <= y_r[i];
      w_r[i+1] <= w_r[i];
      quad_r[i+1] <= quad_r[i];
      if (!cz_r[i][CW-1]) begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] - atan_turn(i);
      end else begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] + atan_turn(i);
      end
    end
  end

  logic signed [15:0] c15, s15;
  assign c15 = to_q15(cx_r[NS-1]);
  assign s15 = to_q15(cy_r[NS-1]);

  always_comb begin
    unique case (quad_r[NS-1])
      2'd0: begin cos_q = c15;  sin_q = s15;  end
      2'd1: begin cos_q = -s15; sin_q = c15;  end
      2'd2: begin cos_q = -c15; sin_q = -s15; end
      default: begin cos_q = s15; sin_q = -c15; end
    endcase
  end

  assign done = vld_r[NS-1];
  assign ox = x_r[NS-1];
  assign oy = y_r[NS-1];
  assign ow = w_r[NS-1];

endmodule

// ===== rtl/owfm_queue.sv =====
// ---------------------------------------------------------------------------
// owfm_queue: short fifo between the rotation front and the wheel back end
// ---------------------------------------------------------------------------
module owfm_queue import owfm_pkg::*; #(
  parameter int WIDTH = 80
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0]  mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;
  logic                pop;
  logic                vld_r;
  logic [WIDTH-1:0]    rdata_r;

  // back end pops whenever an entry is present
  assign pop = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
      vld_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
    if (pop) rdata_r <= mem_r[rp_r];
  end

  assign valid = vld_r;
  assign rdata = rdata_r;

endmodule

// ===== rtl/owfm_back.sv =====
// ---------------------------------------------------------------------------
// owfm_back: wheel products, sums, rounding and saturation
// two stages: products, then sum/round/clamp into the output register
// ---------------------------------------------------------------------------
module owfm_back import owfm_pkg::*; #(
  parameter int VEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic signed [VEL_BITS-1:0]    vx,
  input  logic signed [VEL_BITS-1:0]    vy,
  input  logic signed [VEL_BITS-1:0]    vw,
  input  logic signed [15:0]            cos_q,
  input  logic signed [15:0]            sin_q,
  output logic                          strobe,
  output logic signed [VEL_BITS+1:0]    wa,
  output logic signed [VEL_BITS+1:0]    wb,
  output logic signed [VEL_BITS+1:0]    wc,
  output logic signed [VEL_BITS+1:0]    wd
);

  localparam int PW = VEL_BITS + 16;
  localparam int SW = VEL_BITS + 19;
  localparam int OB = VEL_BITS + 2;
  localparam logic signed [SW-1:0] SAT_HI = $signed(SW'({1'b0, {(OB-1){1'b1}}}));
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  logic                 p_vld_r, o_vld_r;
  logic signed [PW-1:0] xs_r, xc_r, ys_r, yc_r;
  logic signed [SW-1:0] w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      p_vld_r <= go;
      o_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    xs_r <= PW'(vx) * PW'(sin_q);
    xc_r <= PW'(vx) * PW'(cos_q);
    ys_r <= PW'(vy) * PW'(sin_q);
    yc_r <= PW'(vy) * PW'(cos_q);
    w_r  <= SW'(vw) <<< 15;
  end

  function automatic logic signed [OB-1:0] fin(input logic signed [SW-1:0] acc);
    logic signed [SW-1:0] r;
    r = (acc + SW'(16384)) >>> 15;
    if (r > SAT_HI) return SAT_HI[OB-1:0];
    if (r < SAT_LO) return SAT_LO[OB-1:0];
    return r[OB-1:0];
  endfunction

  logic signed [SW-1:0] xs, xc, ys, yc;
  assign xs = SW'(xs_r);
  assign xc = SW'(xc_r);
  assign ys = SW'(ys_r);
  assign yc = SW'(yc_r);

  always_ff @(posedge clk) begin
    wa <= fin(-xs + yc - w_r);
    wb <= fin(-xc - ys - w_r);
    wc <= fin(xs - yc - w_r);
    wd <= fin(xc + ys - w_r);
  end

  assign strobe = o_vld_r;

endmodule

// ===== rtl/omni_wheel_field_mixer.sv =====
// ---------------------------------------------------------------------------
// omni_wheel_field_mixer: field-oriented four-wheel omni inverse kinematics
// ---------------------------------------------------------------------------
// channel  | ports                                   | handshake
// input    | in_vel_x in_vel_y in_turn_rate in_heading | start & !busy
// result   | out_wheel_a..d                          | out_strobe, one cycle
// config   | psel penable pwrite paddr pwdata prdata | apb, pready high
//
// one item per cycle; busy is always low. a result follows an accepted item
// through the 21-stage cordic, queue write and read, and two wheel stages.
// items taken while run_enable is clear give no result.
// reset is synchronous active low and clears the pipeline and run_enable.
// ---------------------------------------------------------------------------
module omni_wheel_field_mixer import owfm_pkg::*; #(
  parameter int VEL_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [VEL_BITS-1:0] in_vel_x,
  input  logic signed [VEL_BITS-1:0] in_vel_y,
  input  logic signed [VEL_BITS-1:0] in_turn_rate,
  input  logic [ANGLE_BITS-1:0]      in_heading,
  output logic                       out_strobe,
  output logic signed [VEL_BITS+1:0] out_wheel_a,
  output logic signed [VEL_BITS+1:0] out_wheel_b,
  output logic signed [VEL_BITS+1:0] out_wheel_c,
  output logic signed [VEL_BITS+1:0] out_wheel_d,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [0:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int QW = 3 * VEL_BITS + 32;

  logic cfg_run_enable_r;
  logic f_done;
  logic signed [VEL_BITS-1:0] f_x, f_y, f_w;
  logic signed [15:0] f_c, f_s;
  logic q_vld;
  logic [QW-1:0] q_rd;

  assign busy = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_run_enable_r <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_RUN_ENABLE) begin
      cfg_run_enable_r <= pwdata[0];
    end
  end

  assign prdata = (paddr == REG_RUN_ENABLE) ? {31'b0, cfg_run_enable_r} : '0;

  owfm_front #(.VEL_BITS(VEL_BITS), .ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk, .rst_n,
    .take(start && !busy && cfg_run_enable_r),
    .vx(in_vel_x), .vy(in_vel_y), .vw(in_turn_rate), .head(in_heading),
    .done(f_done), .ox(f_x), .oy(f_y), .ow(f_w), .cos_q(f_c), .sin_q(f_s)
  );

  owfm_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst_n, .push(f_done),
    .wdata({f_x, f_y, f_w, f_c, f_s}),
    .valid(q_vld), .rdata(q_rd)
  );

  owfm_back #(.VEL_BITS(VEL_BITS)) u_back (
    .clk, .rst_n, .go(q_vld),
    .vx(q_rd[QW-1 -: VEL_BITS]),
    .vy(q_rd[QW-1-VEL_BITS -: VEL_BITS]),
    .vw(q_rd[QW-1-2*VEL_BITS -: VEL_BITS]),
    .cos_q(q_rd[31:16]), .sin_q(q_rd[15:0]),
    .strobe(out_strobe),
    .wa(out_wheel_a), .wb(out_wheel_b), .wc(out_wheel_c), .wd(out_wheel_d)
  );

endmodule

// ===== rtl/owfm_checker.sv =====
// ---------------------------------------------------------------------------
// owfm_checker: port-level checks of the omni mixer
// ---------------------------------------------------------------------------
module owfm_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic pready,
  input logic out_strobe,
  input logic psel,
  input logic penable
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_ready: assert property (@(posedge clk) pready) else $error("pready low");
  // a result needs an item taken well before it
  a_no_early: assert property (@(posedge clk) $rose(rst_n) |-> ##1 !out_strobe)
    else $error("result right after reset");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result during reset");
  // access phase only follows a setup phase
  a_apb_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable) |-> $past(psel && !penable))
    else $error("access without setup");

endmodule

bind omni_wheel_field_mixer owfm_checker u_owfm_checker (
  .clk, .rst_n, .busy, .pready, .out_strobe, .psel, .penable
);
